// ===== sv/rmth_pkg.sv =====
// shared constants and types for the running median block
package rmth_pkg;
  localparam int unsigned DataWidth = 32;
  localparam int unsigned HeapDepth = 512;
  localparam int unsigned MedianWidth = 32;
  localparam int unsigned CountWidth = 11;

  // heap unit command
  typedef enum logic [1:0] {
    HOP_PUSH = 2'd0,
    HOP_REPLACE = 2'd1
  } heap_op_e;
endpackage

// ===== sv/rmth_heap.sv =====
// one binary heap in a memory, with an iterative sift-up / sift-down sequencer
module rmth_heap #(
  parameter int unsigned DataWidth = rmth_pkg::DataWidth,
  parameter int unsigned HeapDepth = rmth_pkg::HeapDepth,
  parameter bit IsMax = 1'b1,
  localparam int unsigned AW = (HeapDepth > 1) ? $clog2(HeapDepth) : 1,
  localparam int unsigned SW = $clog2(HeapDepth + 1)
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  rmth_pkg::heap_op_e   op_i,
  input  logic [DataWidth-1:0] value_i,
  input  logic                 clear_i,
  output logic                 busy_o,
  output logic [DataWidth-1:0] top_o,
  output logic [SW-1:0]        size_o
);

  typedef enum logic [2:0] {
    ST_IDLE, ST_UP_RD, ST_UP_CMP, ST_DN_RDL, ST_DN_RDR, ST_DN_CMP, ST_DN_WR
  } state_e;

  logic [DataWidth-1:0] mem_q [HeapDepth];
  logic [DataWidth-1:0] rd_q, val_q, top_q, left_q;
  logic [AW-1:0]        pos_q, child_q;
  logic [SW-1:0]        size_q;
  state_e               state_q;
  logic                 wr_en;
  logic [AW-1:0]        wr_addr, rd_addr;
  logic [DataWidth-1:0] wr_data;

  logic [SW:0] pos_w, lpos_w, rpos_w;
  logic [AW-1:0] parent_w;
  assign pos_w = {{(SW+1-AW){1'b0}}, pos_q};
  assign lpos_w = (pos_w << 1) + (SW+1)'(1);
  assign rpos_w = (pos_w << 1) + (SW+1)'(2);
  assign parent_w = AW'(({1'b0, pos_q} - (AW+1)'(1)) >> 1);

  logic [SW:0] size_w;
  assign size_w = {1'b0, size_q};

  function automatic logic above(logic [DataWidth-1:0] a, logic [DataWidth-1:0] b);
    above = IsMax ? (a > b) : (a < b);
  endfunction

  // child selection during sift-down; rd_q holds the right child
  logic take_r, take_l;
  assign take_r = (rpos_w < size_w) && above(rd_q, left_q) && above(rd_q, val_q);
  assign take_l = above(left_q, val_q);

  // memory port
  always_ff @(posedge clk_i) begin
    if (wr_en) mem_q[wr_addr] <= wr_data;
    rd_q <= mem_q[rd_addr];
  end

  always_comb begin
    wr_en = 1'b0;
    wr_addr = pos_q;
    wr_data = val_q;
    rd_addr = parent_w;
    case (state_q)
      ST_IDLE: begin
        if (start_i && op_i == rmth_pkg::HOP_PUSH && size_q < SW'(HeapDepth)) begin
          wr_en = 1'b1; wr_addr = size_q[AW-1:0]; wr_data = value_i;
          rd_addr = AW'(({1'b0, size_q[AW-1:0]} - (AW+1)'(1)) >> 1);
        end else if (start_i && op_i == rmth_pkg::HOP_REPLACE && size_q != '0) begin
          wr_en = 1'b1; wr_addr = '0; wr_data = value_i;
        end
      end
      ST_UP_CMP: begin
        // parent moves down, or the new value settles here
        wr_en = 1'b1;
        wr_data = above(val_q, rd_q) ? rd_q : val_q;
      end
      ST_DN_RDL: begin
        rd_addr = lpos_w[AW-1:0];
        // leaf reached: the sifted value settles here
        if (lpos_w >= size_w) wr_en = 1'b1;
      end
      ST_DN_RDR: rd_addr = rpos_w[AW-1:0];
      ST_DN_CMP: begin
        // winning child moves up, or the sifted value settles here
        wr_en = 1'b1;
        wr_data = take_r ? rd_q : (take_l ? left_q : val_q);
      end
      ST_DN_WR: begin
        wr_en = 1'b1; wr_addr = child_q; wr_data = val_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      size_q <= '0;
      pos_q <= '0;
      child_q <= '0;
      val_q <= '0;
      top_q <= '0;
      left_q <= '0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (clear_i) size_q <= '0;
          else if (start_i && op_i == rmth_pkg::HOP_PUSH && size_q < SW'(HeapDepth)) begin
            val_q <= value_i;
            pos_q <= size_q[AW-1:0];
            size_q <= size_q + SW'(1);
            if (size_q == '0) top_q <= value_i;
            else state_q <= ST_UP_RD;
          end else if (start_i && op_i == rmth_pkg::HOP_REPLACE && size_q != '0) begin
            val_q <= value_i;
            top_q <= value_i;
            pos_q <= '0;
            state_q <= ST_DN_RDL;
          end
        end
        ST_UP_RD: state_q <= ST_UP_CMP;
        ST_UP_CMP: begin
          if (above(val_q, rd_q)) begin
            pos_q <= parent_w;
            if (parent_w == '0) begin
              top_q <= val_q;
              state_q <= ST_DN_WR;
              child_q <= '0;
            end else state_q <= ST_UP_RD;
          end else state_q <= ST_IDLE;
        end
        ST_DN_RDL: begin
          if (lpos_w < size_w) state_q <= ST_DN_RDR;
          else state_q <= ST_IDLE;
        end
        ST_DN_RDR: begin
          left_q <= rd_q;
          state_q <= ST_DN_CMP;
        end
        ST_DN_CMP: begin
          if (take_r) begin
            pos_q <= rpos_w[AW-1:0];
            if (pos_q == '0) top_q <= rd_q;
            state_q <= ST_DN_RDL;
          end else if (take_l) begin
            pos_q <= lpos_w[AW-1:0];
            if (pos_q == '0) top_q <= left_q;
            state_q <= ST_DN_RDL;
          end else state_q <= ST_IDLE;
        end
        ST_DN_WR: state_q <= ST_IDLE;
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign busy_o = (state_q != ST_IDLE);
  assign top_o = top_q;
  assign size_o = size_q;

endmodule

// ===== sv/running_median_two_heaps.sv =====
// top level: running lower median kept in a max-heap and a min-heap
//
//  channel | handshake           | fields
//  in      | in_valid/in_stall   | first_i, sample_i
//  out     | out_valid/out_stall | median_o, count_o, dropped_o
//
// a sample needs at most one sift-up and one sift-down from accept to result beat;
// a sift-up level reads, then compares and writes; a sift-down level reads the left
// child, then the right, then compares and writes, walking each heap's memory port.
// no reset pass: heap contents are undefined until written, sizes reset to 0.
// a finished result sits in the output register; the next sample is taken
// only once that register is free, so a sample waits until the last result beat is taken.
module running_median_two_heaps #(
  parameter int unsigned DATA_WIDTH = rmth_pkg::DataWidth,
  parameter int unsigned HEAP_DEPTH = rmth_pkg::HeapDepth,
  localparam int unsigned SW = $clog2(HEAP_DEPTH + 1)
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        first_i,
  input  logic [31:0] sample_i,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] median_o,
  output logic [10:0] count_o,
  output logic        dropped_o
);

  typedef enum logic [2:0] {S_IDLE, S_DEC, S_OP1, S_W1, S_OP2, S_W2, S_OUT} state_e;

  state_e state_q;
  logic [DATA_WIDTH-1:0] v_q;
  logic drop_q;

  logic lo_start, hi_start, lo_busy, hi_busy;
  rmth_pkg::heap_op_e lo_op, hi_op;
  logic [DATA_WIDTH-1:0] lo_val, hi_val, lo_top, hi_top;
  logic [SW-1:0] lo_size, hi_size;

  // plan for the sample, worked out in S_DEC
  typedef enum logic [2:0] {
    P_LO_PUSH, P_HI_PUSH, P_LO_UP, P_HI_DOWN
  } plan_e;
  plan_e plan_q;

  logic accept;
  assign in_stall = (state_q != S_IDLE) || out_valid;
  assign accept = in_valid && !in_stall;

  logic [SW:0] total;
  assign total = {1'b0, lo_size} + {1'b0, hi_size};

  always_comb begin
    lo_start = 1'b0; hi_start = 1'b0;
    lo_op = rmth_pkg::HOP_PUSH; hi_op = rmth_pkg::HOP_PUSH;
    lo_val = v_q; hi_val = v_q;
    if (state_q == S_OP1) begin
      case (plan_q)
        P_LO_PUSH: lo_start = 1'b1;
        P_HI_PUSH: hi_start = 1'b1;
        // lower top moves up, then sample replaces the lower root
        P_LO_UP: begin hi_start = 1'b1; hi_val = lo_top; end
        P_HI_DOWN: begin lo_start = 1'b1; lo_val = hi_top; end
        default: ;
      endcase
    end else if (state_q == S_OP2) begin
      if (plan_q == P_LO_UP) begin lo_start = 1'b1; lo_op = rmth_pkg::HOP_REPLACE; end
      if (plan_q == P_HI_DOWN) begin hi_start = 1'b1; hi_op = rmth_pkg::HOP_REPLACE; end
    end
  end

  rmth_heap #(.DataWidth(DATA_WIDTH), .HeapDepth(HEAP_DEPTH), .IsMax(1'b1)) u_lo (
    .clk_i, .rst_ni, .start_i(lo_start), .op_i(lo_op), .value_i(lo_val),
    .clear_i(accept && first_i), .busy_o(lo_busy), .top_o(lo_top), .size_o(lo_size));
  rmth_heap #(.DataWidth(DATA_WIDTH), .HeapDepth(HEAP_DEPTH), .IsMax(1'b0)) u_hi (
    .clk_i, .rst_ni, .start_i(hi_start), .op_i(hi_op), .value_i(hi_val),
    .clear_i(accept && first_i), .busy_o(hi_busy), .top_o(hi_top), .size_o(hi_size));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      out_valid <= 1'b0;
      plan_q <= P_LO_PUSH;
      v_q <= '0;
      drop_q <= 1'b0;
      median_o <= '0;
      count_o <= '0;
      dropped_o <= 1'b0;
    end else begin
      if (out_valid && !out_stall) out_valid <= 1'b0;
      case (state_q)
        S_IDLE: if (accept) begin
          v_q <= DATA_WIDTH'(sample_i);
          state_q <= S_DEC;
        end
        S_DEC: begin
          drop_q <= (total >= (SW+1)'(2*HEAP_DEPTH));
          if (total >= (SW+1)'(2*HEAP_DEPTH)) state_q <= S_OUT;
          else begin
            state_q <= S_OP1;
            if (lo_size == '0) plan_q <= P_LO_PUSH;
            else if (v_q <= lo_top) plan_q <= (lo_size > hi_size) ? P_LO_UP : P_LO_PUSH;
            else if (lo_size > hi_size) plan_q <= P_HI_PUSH;
            else if (hi_size == '0 || v_q <= hi_top) plan_q <= P_LO_PUSH;
            else plan_q <= P_HI_DOWN;
          end
        end
        S_OP1: state_q <= S_W1;
        S_W1: if (!lo_busy && !hi_busy)
          state_q <= (plan_q == P_LO_UP || plan_q == P_HI_DOWN) ? S_OP2 : S_OUT;
        S_OP2: state_q <= S_W2;
        S_W2: if (!lo_busy && !hi_busy) state_q <= S_OUT;
        S_OUT: begin
          median_o <= (lo_size != '0) ? 32'(lo_top) : '0;
          count_o <= 11'(total);
          dropped_o <= drop_q;
          out_valid <= 1'b1;
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== sv/rmth_checker.sv =====
// port-level checks for the running median block
module rmth_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [10:0] count_o,
  input logic        dropped_o
);
  // a busy block never takes a beat while a result waits
  a_no_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> in_stall) else $error("input taken with result pending");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_stall |=> out_valid && $stable(count_o))
    else $error("stalled result changed");
  a_drop_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && dropped_o |-> count_o != 11'd0) else $error("drop with empty set");
  a_accept_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && !in_stall |=> in_stall) else $error("no busy after accept");
endmodule

bind running_median_two_heaps rmth_checker u_rmth_checker (
  .clk_i, .rst_ni, .in_valid, .in_stall, .out_valid, .out_stall, .count_o, .dropped_o);

// ===== test/tb.sv =====
// testbench for running_median_two_heaps: directed table, then checked random sequences
`timescale 1ns / 1ps

module tb;

  localparam int unsigned Depth = rmth_pkg::HeapDepth;
  localparam int unsigned WatchdogLimit = 20000;
  localparam int unsigned HoldCycles = 400;

  typedef struct packed {
    logic [31:0] median;
    logic [10:0] count;
    logic        dropped;
  } median_beat_t;

  typedef struct {
    logic        first;
    logic [31:0] sample;
    bit          typed;
    logic [31:0] median;
    logic [10:0] count;
    logic        dropped;
  } table_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        first_i = 1'b0;
  logic [31:0] sample_i = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] median_o;
  logic [10:0] count_o;
  logic        dropped_o;

  // predictor state: lower half max-heap, upper half min-heap
  logic [31:0] lo_heap [Depth];
  logic [31:0] hi_heap [Depth];
  int unsigned lo_size;
  int unsigned hi_size;

  median_beat_t median_q[$];
  int unsigned  n_errors = 0;
  int unsigned  n_sent = 0;
  int unsigned  n_recv = 0;
  int unsigned  n_drops = 0;
  int unsigned  send_idle_pct = 0;
  int unsigned  recv_stall_pct = 0;
  int unsigned  hold_reqs = 0;
  int unsigned  hold_taken = 0;
  int unsigned  hold_cycles = 0;

  running_median_two_heaps i_dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .first_i   (first_i),
    .sample_i  (sample_i),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .median_o  (median_o),
    .count_o   (count_o),
    .dropped_o (dropped_o)
  );

  always #2 clk_i = ~clk_i;

  function automatic bit outranks(logic [31:0] a, logic [31:0] b, bit is_max);
    return is_max ? (a > b) : (a < b);
  endfunction

  // append at the bottom and bubble up while strictly better than the parent
  function automatic void heap_push(bit is_max, logic [31:0] v);
    int unsigned pos;
    int unsigned par;
    logic [31:0] t;
    if (is_max) begin
      if (lo_size >= Depth) return;
      pos = lo_size;
      lo_heap[pos] = v;
      while (pos > 0) begin
        par = (pos - 1) / 2;
        if (!outranks(lo_heap[pos], lo_heap[par], 1'b1)) break;
        t = lo_heap[pos]; lo_heap[pos] = lo_heap[par]; lo_heap[par] = t;
        pos = par;
      end
      lo_size++;
    end else begin
      if (hi_size >= Depth) return;
      pos = hi_size;
      hi_heap[pos] = v;
      while (pos > 0) begin
        par = (pos - 1) / 2;
        if (!outranks(hi_heap[pos], hi_heap[par], 1'b0)) break;
        t = hi_heap[pos]; hi_heap[pos] = hi_heap[par]; hi_heap[par] = t;
        pos = par;
      end
      hi_size++;
    end
  endfunction

  // new root, then sift down; ties stay in place
  function automatic void heap_swap_root(bit is_max, logic [31:0] v);
    int unsigned pos;
    int unsigned l;
    int unsigned r;
    int unsigned best;
    int unsigned sz;
    logic [31:0] t;
    sz = is_max ? lo_size : hi_size;
    if (sz == 0) return;
    pos = 0;
    if (is_max) lo_heap[0] = v; else hi_heap[0] = v;
    forever begin
      l = 2 * pos + 1;
      r = l + 1;
      best = pos;
      if (is_max) begin
        if (l < sz && outranks(lo_heap[l], lo_heap[best], 1'b1)) best = l;
        if (r < sz && outranks(lo_heap[r], lo_heap[best], 1'b1)) best = r;
        if (best == pos) break;
        t = lo_heap[pos]; lo_heap[pos] = lo_heap[best]; lo_heap[best] = t;
      end else begin
        if (l < sz && outranks(hi_heap[l], hi_heap[best], 1'b0)) best = l;
        if (r < sz && outranks(hi_heap[r], hi_heap[best], 1'b0)) best = r;
        if (best == pos) break;
        t = hi_heap[pos]; hi_heap[pos] = hi_heap[best]; hi_heap[best] = t;
      end
      pos = best;
    end
  endfunction

  // one sample into the running set, returns the lower median beat
  function automatic median_beat_t add_sample(logic first, logic [31:0] v);
    median_beat_t res;
    res.dropped = 1'b0;
    if (first) begin
      lo_size = 0;
      hi_size = 0;
    end
    if (lo_size + hi_size >= 2 * Depth) begin
      res.dropped = 1'b1;
    end else if (lo_size == 0) begin
      heap_push(1'b1, v);
    end else if (v <= lo_heap[0]) begin
      if (lo_size > hi_size) begin
        heap_push(1'b0, lo_heap[0]);
        heap_swap_root(1'b1, v);
      end else begin
        heap_push(1'b1, v);
      end
    end else if (lo_size > hi_size) begin
      heap_push(1'b0, v);
    end else if (hi_size == 0 || v <= hi_heap[0]) begin
      heap_push(1'b1, v);
    end else begin
      heap_push(1'b1, hi_heap[0]);
      heap_swap_root(1'b0, v);
    end
    res.median = (lo_size > 0) ? lo_heap[0] : '0;
    res.count = 11'(lo_size + hi_size);
    return res;
  endfunction

  // offer one beat and hold it until taken; leaves in_valid high
  task automatic offer_sample(logic first, logic [31:0] v, bit typed, median_beat_t typed_res);
    median_beat_t res;
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    first_i  <= first;
    sample_i <= v;
    do @(posedge clk_i); while (in_stall);
    res = add_sample(first, v);
    median_q.push_back(typed ? typed_res : res);
    n_sent++;
    if (res.dropped) n_drops++;
  endtask

  // let the block drain completely before moving on
  task automatic drain();
    in_valid <= 1'b0;
    while (median_q.size() != 0) @(posedge clk_i);
  endtask

  // receiver: random stall, or a long hold-off when asked
  always @(posedge clk_i) begin
    if (hold_reqs != hold_taken) begin
      hold_taken <= hold_reqs;
      hold_cycles <= HoldCycles - 1;
      out_stall <= 1'b1;
    end else if (hold_cycles != 0) begin
      out_stall <= 1'b1;
      hold_cycles <= hold_cycles - 1;
    end else begin
      out_stall <= (recv_stall_pct != 0) && ($urandom_range(99) < recv_stall_pct);
    end
  end

  // result checker against the oldest pending beat
  always @(posedge clk_i) begin
    median_beat_t exp_beat;
    if (rst_ni && out_valid && !out_stall) begin
      n_recv++;
      if (median_q.size() == 0) begin
        $error("result beat with nothing pending: median %0h count %0d", median_o, count_o);
        n_errors++;
      end else begin
        exp_beat = median_q.pop_front();
        if (median_o !== exp_beat.median) begin
          $error("median: expected %0h, got %0h", exp_beat.median, median_o);
          n_errors++;
        end
        if (count_o !== exp_beat.count) begin
          $error("count: expected %0d, got %0d", exp_beat.count, count_o);
          n_errors++;
        end
        if (dropped_o !== exp_beat.dropped) begin
          $error("dropped: expected %0b, got %0b", exp_beat.dropped, dropped_o);
          n_errors++;
        end
      end
    end
  end

  // watchdog on cycles without any handshake
  int unsigned quiet_cycles = 0;
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WatchdogLimit) begin
      $display("timeout after %0d quiet cycles", quiet_cycles);
      $display("[running_median_two_heaps] ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // directed rows: typed results where the heaps are easy to follow by hand
  table_row_t dir_rows[] = '{
    '{1'b1, 32'd5,          1'b1, 32'd5,          11'd1, 1'b0},
    '{1'b0, 32'd3,          1'b1, 32'd3,          11'd2, 1'b0},
    '{1'b0, 32'hFFFF_FFFF,  1'b1, 32'd5,          11'd3, 1'b0},
    '{1'b0, 32'd0,          1'b1, 32'd3,          11'd4, 1'b0},
    '{1'b1, 32'hFFFF_FFFF,  1'b1, 32'hFFFF_FFFF,  11'd1, 1'b0},
    '{1'b0, 32'hFFFF_FFFF,  1'b1, 32'hFFFF_FFFF,  11'd2, 1'b0},
    '{1'b0, 32'd0,          1'b1, 32'hFFFF_FFFF,  11'd3, 1'b0},
    '{1'b0, 32'd0,          1'b1, 32'd0,          11'd4, 1'b0},
    '{1'b1, 32'd0,          1'b1, 32'd0,          11'd1, 1'b0},
    // ties and ordered runs from here on go through the predictor
    '{1'b0, 32'd7,          1'b0, '0, '0, 1'b0},
    '{1'b0, 32'd7,          1'b0, '0, '0, 1'b0},
    '{1'b0, 32'd7,          1'b0, '0, '0, 1'b0},
    '{1'b0, 32'd7,          1'b0, '0, '0, 1'b0},
    '{1'b0, 32'h8000_0000,  1'b0, '0, '0, 1'b0},
    '{1'b0, 32'h7FFF_FFFF,  1'b0, '0, '0, 1'b0},
    '{1'b1, 32'd100,        1'b0, '0, '0, 1'b0},
    '{1'b0, 32'd90,         1'b0, '0, '0, 1'b0},
    '{1'b0, 32'd80,         1'b0, '0, '0, 1'b0},
    '{1'b0, 32'd70,         1'b0, '0, '0, 1'b0},
    '{1'b0, 32'd110,        1'b0, '0, '0, 1'b0},
    '{1'b0, 32'd120,        1'b0, '0, '0, 1'b0},
    '{1'b0, 32'hAAAA_5555,  1'b0, '0, '0, 1'b0}
  };

  function automatic logic [31:0] pick_value(int unsigned mode);
    case (mode)
      0: return 32'($urandom_range(15));
      1: return $urandom();
      default: return ($urandom_range(1) != 0) ? 32'hFFFF_FFF0 | 32'($urandom_range(15))
                                               : 32'($urandom_range(3));
    endcase
  endfunction

  // a sequence opens with first high; a few carry first mid-run as noise
  task automatic run_sequence(int unsigned len);
    int unsigned mode;
    mode = $urandom_range(2);
    for (int unsigned k = 0; k < len; k++) begin
      offer_sample((k == 0) || ($urandom_range(99) == 0), pick_value(mode), 1'b0, '0);
    end
  endtask

  initial begin
    median_beat_t typed_res;
    int unsigned phase_items;
    int unsigned seq_len;
    lo_size = 0;
    hi_size = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) begin
      typed_res = '{median: dir_rows[i].median, count: dir_rows[i].count,
                    dropped: dir_rows[i].dropped};
      offer_sample(dir_rows[i].first, dir_rows[i].sample, dir_rows[i].typed, typed_res);
    end
    drain();

    // occasionally idle sender, heavily stalled receiver
    send_idle_pct = 24;
    recv_stall_pct = 82;
    phase_items = 0;
    while (phase_items < 260) begin
      seq_len = $urandom_range(1, 40);
      run_sequence(seq_len);
      phase_items += seq_len;
    end
    drain();

    // rates swapped over: sparse sender, lightly stalled receiver
    send_idle_pct = 82;
    recv_stall_pct = 24;
    phase_items = 0;
    while (phase_items < 240) begin
      seq_len = $urandom_range(1, 45);
      run_sequence(seq_len);
      phase_items += seq_len;
    end
    drain();

    // no idling; a long hold-off at the start, then a full sequence fills storage and overflows
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_reqs++;
    offer_sample(1'b1, $urandom(), 1'b0, '0);
    for (int unsigned k = 1; k < 2 * Depth + 6; k++) begin
      offer_sample(1'b0, pick_value(k % 3), 1'b0, '0);
    end
    run_sequence(12);
    drain();

    repeat (100) @(posedge clk_i);
    $display("sent %0d samples, checked %0d result beats, %0d overflow drops",
             n_sent, n_recv, n_drops);
    if (n_errors == 0 && median_q.size() == 0) begin
      $display("[running_median_two_heaps] OK");
    end else begin
      $display("[running_median_two_heaps] ERROR");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/rmth_pkg.sv
sv/rmth_heap.sv
sv/running_median_two_heaps.sv
sv/rmth_checker.sv
test/tb.sv
